/* sv/lcd_nibble_write_sequencer_macros.svh */
// Assertion helpers for the LCD write sequencer.
// Both expect clk and arst_n in scope.
`ifndef LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

`define LCDNWS_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`define LCDNWS_IMPLIES_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lcdnws_pkg.sv */
package lcdnws_pkg;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  value;
		logic [11:0] extra_hold_us;
	} req_t;

	typedef struct packed {
		logic [3:0]  data_nibble;
		logic        reg_select;
		logic        enable;
		logic [17:0] hold_us;
		logic        last;
	} act_t;

	localparam int HOLD_W = 18;
	localparam int STROBE_W = 10;
	localparam int SETTLE_W = 14;
	localparam int EXTRA_W = 12;
	localparam int PC_W = 5;
	localparam int CMD_W = 3;

	localparam logic [1:0] FUNC_CMD  = 2'd0;
	localparam logic [1:0] FUNC_DATA = 2'd1;
	localparam logic [1:0] FUNC_INIT = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	localparam logic CFG_STROBE = 1'b0;
	localparam logic CFG_SETTLE = 1'b1;

	// nibble source
	localparam logic [1:0] NIB_CONST = 2'd0;
	localparam logic [1:0] NIB_HI    = 2'd1;
	localparam logic [1:0] NIB_LO    = 2'd2;

	// RS source
	localparam logic [1:0] RS_ZERO = 2'd0;
	localparam logic [1:0] RS_BYTE = 2'd1;
	localparam logic [1:0] RS_FLIP = 2'd2;

	// hold source
	localparam logic [1:0] HOLD_STROBE  = 2'd0;
	localparam logic [1:0] HOLD_CONST   = 2'd1;
	localparam logic [1:0] HOLD_CONST_S = 2'd2;
	localparam logic [1:0] HOLD_SETTLE  = 2'd3;

	localparam logic [PC_W-1:0]  PC_WAKE     = 5'd0;
	localparam logic [PC_W-1:0]  PC_BYTE     = 5'd11;
	localparam logic [PC_W-1:0]  PC_LAST     = 5'd17;
	localparam logic [CMD_W-1:0] CMD_LAST    = 3'd4;

	typedef struct packed {
		logic [1:0]        nib_sel;
		logic [3:0]        nib_const;
		logic [1:0]        rs_sel;
		logic              en;
		logic [1:0]        hold_sel;
		logic [HOLD_W-1:0] hold_const;
		logic              byte_end;
	} uop_t;

	function automatic logic [7:0] init_cmd(input logic [CMD_W-1:0] idx);
		case (idx)
			3'd0:    init_cmd = 8'h2c;
			3'd1:    init_cmd = 8'h08;
			3'd2:    init_cmd = 8'h08;
			3'd3:    init_cmd = 8'h06;
			3'd4:    init_cmd = 8'h0e;
			default: init_cmd = 8'h00;
		endcase
	endfunction

	function automatic logic [EXTRA_W-1:0] init_gap(input logic [CMD_W-1:0] idx);
		case (idx)
			3'd2:    init_gap = 12'd3000;
			default: init_gap = 12'd100;
		endcase
	endfunction

endpackage

/* sv/lcdnws_urom.sv */
module lcdnws_urom (
	input  logic [lcdnws_pkg::PC_W-1:0] pc,
	output lcdnws_pkg::uop_t            uop
);
	import lcdnws_pkg::*;

	function automatic uop_t mk(input logic [1:0] ns, input logic [3:0] nc,
		input logic [1:0] rs, input logic en, input logic [1:0] hs,
		input logic [HOLD_W-1:0] hc, input logic be);
		uop_t u;
		u.nib_sel = ns;
		u.nib_const = nc;
		u.rs_sel = rs;
		u.en = en;
		u.hold_sel = hs;
		u.hold_const = hc;
		u.byte_end = be;
		return u;
	endfunction

	always_comb begin
		case (pc)
			// wake-up pattern
			5'd0:  uop = mk(NIB_CONST, 4'd0, RS_ZERO, 1'b0, HOLD_CONST, 18'd150000, 1'b0);
			5'd1:  uop = mk(NIB_CONST, 4'd3, RS_ZERO, 1'b0, HOLD_STROBE, 18'd0, 1'b0);
			5'd2:  uop = mk(NIB_CONST, 4'd3, RS_ZERO, 1'b1, HOLD_STROBE, 18'd0, 1'b0);
			5'd3:  uop = mk(NIB_CONST, 4'd3, RS_ZERO, 1'b0, HOLD_CONST_S, 18'd12000, 1'b0);
			5'd4:  uop = mk(NIB_CONST, 4'd3, RS_ZERO, 1'b1, HOLD_STROBE, 18'd0, 1'b0);
			5'd5:  uop = mk(NIB_CONST, 4'd3, RS_ZERO, 1'b0, HOLD_CONST, 18'd100, 1'b0);
			5'd6:  uop = mk(NIB_CONST, 4'd3, RS_ZERO, 1'b1, HOLD_STROBE, 18'd0, 1'b0);
			5'd7:  uop = mk(NIB_CONST, 4'd3, RS_ZERO, 1'b0, HOLD_CONST, 18'd100, 1'b0);
			5'd8:  uop = mk(NIB_CONST, 4'd2, RS_ZERO, 1'b0, HOLD_STROBE, 18'd0, 1'b0);
			5'd9:  uop = mk(NIB_CONST, 4'd2, RS_ZERO, 1'b1, HOLD_STROBE, 18'd0, 1'b0);
			5'd10: uop = mk(NIB_CONST, 4'd2, RS_ZERO, 1'b0, HOLD_CONST, 18'd1000, 1'b0);
			// byte routine
			5'd11: uop = mk(NIB_HI, 4'd0, RS_BYTE, 1'b0, HOLD_STROBE, 18'd0, 1'b0);
			5'd12: uop = mk(NIB_HI, 4'd0, RS_BYTE, 1'b1, HOLD_STROBE, 18'd0, 1'b0);
			5'd13: uop = mk(NIB_HI, 4'd0, RS_BYTE, 1'b0, HOLD_STROBE, 18'd0, 1'b0);
			5'd14: uop = mk(NIB_LO, 4'd0, RS_BYTE, 1'b0, HOLD_STROBE, 18'd0, 1'b0);
			5'd15: uop = mk(NIB_LO, 4'd0, RS_BYTE, 1'b1, HOLD_STROBE, 18'd0, 1'b0);
			5'd16: uop = mk(NIB_LO, 4'd0, RS_BYTE, 1'b0, HOLD_STROBE, 18'd0, 1'b0);
			5'd17: uop = mk(NIB_LO, 4'd0, RS_FLIP, 1'b0, HOLD_SETTLE, 18'd0, 1'b1);
			default: uop = mk(NIB_CONST, 4'd0, RS_ZERO, 1'b0, HOLD_CONST, 18'd0, 1'b1);
		endcase
	end

endmodule

/* sv/lcdnws_dp.sv */
module lcdnws_dp (
	input  lcdnws_pkg::uop_t                  uop,
	input  logic [1:0]                        mode,
	input  logic [7:0]                        byte_val,
	input  logic [lcdnws_pkg::EXTRA_W-1:0]    extra,
	input  logic [lcdnws_pkg::CMD_W-1:0]      cmd_idx,
	input  logic [lcdnws_pkg::STROBE_W-1:0]   strobe,
	input  logic [lcdnws_pkg::SETTLE_W-1:0]   settle,
	output lcdnws_pkg::act_t                  act
);
	import lcdnws_pkg::*;

	logic               is_init;
	logic               is_data;
	logic [7:0]         cur_byte;
	logic [EXTRA_W-1:0] cur_extra;
	logic [HOLD_W-1:0]  s_ext;

	assign is_init   = (mode == FUNC_INIT);
	assign is_data   = (mode == FUNC_DATA);
	assign cur_byte  = is_init ? init_cmd(cmd_idx) : byte_val;
	assign cur_extra = is_init ? init_gap(cmd_idx) : extra;
	assign s_ext     = {{(HOLD_W-STROBE_W){1'b0}}, strobe};

	always_comb begin
		case (uop.nib_sel)
			NIB_HI:  act.data_nibble = cur_byte[7:4];
			NIB_LO:  act.data_nibble = cur_byte[3:0];
			default: act.data_nibble = uop.nib_const;
		endcase
		case (uop.rs_sel)
			RS_BYTE: act.reg_select = is_data;
			RS_FLIP: act.reg_select = ~is_data;
			default: act.reg_select = 1'b0;
		endcase
		case (uop.hold_sel)
			HOLD_CONST:   act.hold_us = uop.hold_const;
			HOLD_CONST_S: act.hold_us = uop.hold_const + s_ext;
			HOLD_SETTLE:  act.hold_us = {{(HOLD_W-SETTLE_W){1'b0}}, settle}
				+ {{(HOLD_W-EXTRA_W){1'b0}}, cur_extra};
			default:      act.hold_us = s_ext;
		endcase
		act.enable = uop.en;
		// init repeats the byte routine until its fifth command
		act.last = uop.byte_end && (!is_init || cmd_idx == CMD_LAST);
	end

endmodule

/* sv/lcd_nibble_write_sequencer.sv */
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    in_data  (req_t: func, value, extra_hold_us)
// out       out  out_valid/out_ready  out_data (act_t: nibble, RS, E, hold, last)
// cfg       in   cfg_we               cfg_index, cfg_data
//
// One pin action per cycle from a microcode step counter; a byte write emits
// 7 pin actions, init 46. The next request is taken once the final action has
// been loaded into the output register. func 3 is accepted and produces nothing.
// A stalled output register freezes the step counter. Reset clears control and
// restores the strobe and settle defaults; data registers are not reset.
`include "lcd_nibble_write_sequencer_macros.svh"

module lcd_nibble_write_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lcdnws_pkg::req_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output lcdnws_pkg::act_t   out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [13:0]        cfg_data
);
	import lcdnws_pkg::*;

	logic                busy_q;
	logic [PC_W-1:0]     pc_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [1:0]          mode_q;
	logic [7:0]          byte_q;
	logic [EXTRA_W-1:0]  extra_q;
	logic [STROBE_W-1:0] strobe_q;
	logic [SETTLE_W-1:0] settle_q;
	logic                out_valid_q;
	act_t                out_q;
	uop_t                uop;
	act_t                act;
	logic                accept;
	logic                start;
	logic                load;

	assign in_ready  = ~busy_q;
	assign accept    = in_valid & in_ready;
	assign start     = accept && (in_data.func != FUNC_NONE);
	assign load      = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	lcdnws_urom u_rom (
		.pc  (pc_q),
		.uop (uop)
	);

	lcdnws_dp u_dp (
		.uop      (uop),
		.mode     (mode_q),
		.byte_val (byte_q),
		.extra    (extra_q),
		.cmd_idx  (cmd_q),
		.strobe   (strobe_q),
		.settle   (settle_q),
		.act      (act)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 10'd25;
			settle_q <= 14'd300;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STROBE: strobe_q <= cfg_data[STROBE_W-1:0];
				CFG_SETTLE: settle_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= PC_WAKE;
			cmd_q       <= '0;
			mode_q      <= FUNC_CMD;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				mode_q <= in_data.func;
				cmd_q  <= '0;
				pc_q   <= (in_data.func == FUNC_INIT) ? PC_WAKE : PC_BYTE;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				if (act.last) begin
					busy_q <= 1'b0;
				end else if (uop.byte_end) begin
					cmd_q <= cmd_q + 1'b1;
					pc_q  <= PC_BYTE;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			byte_q  <= in_data.value;
			extra_q <= in_data.extra_hold_us;
		end
		if (load) begin
			out_q <= act;
		end
	end

	`LCDNWS_IMPLIES_NEXT(a_start_entry, start, busy_q && (pc_q == PC_WAKE || pc_q == PC_BYTE), "sequencer did not enter at a routine entry")
	`LCDNWS_IMPLIES_NEXT(a_last_idle, load && act.last, !busy_q && out_valid && out_data.last, "final action did not release the sequencer")
	`LCDNWS_ALWAYS(a_pc_range, !busy_q || pc_q <= PC_LAST, "step counter ran past the program")
	`LCDNWS_ALWAYS(a_cmd_range, cmd_q <= CMD_LAST, "init command index out of range")

endmodule

/* tb/sv/lcd_nibble_write_sequencer_tb.sv */
module lcd_nibble_write_sequencer_tb;
	import lcdnws_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_SHOWN = 10;
	localparam int RANDOM_PER_PHASE = 38;

	localparam logic [HOLD_W-1:0] POWERUP_HOLD = 18'd150000;
	localparam logic [HOLD_W-1:0] WAKE_LONG_HOLD = 18'd12000;
	localparam logic [HOLD_W-1:0] WAKE_SHORT_HOLD = 18'd100;
	localparam logic [HOLD_W-1:0] WAKE_4BIT_HOLD = 18'd1000;
	localparam logic [11:0] CLEAR_EXTRA = 12'd3000;

	// startup instruction bytes; the third one is 0x08 on purpose
	localparam logic [7:0] STARTUP_BYTES [5] = '{8'h2c, 8'h08, 8'h08, 8'h06, 8'h0e};
	localparam logic [11:0] STARTUP_GAPS [5] = '{12'd100, 12'd100, 12'd3000, 12'd100, 12'd100};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	req_t        in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	act_t        out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_STROBE;
	logic [13:0] cfg_data = '0;

	logic [STROBE_W-1:0] strobe_us = 10'd25;
	logic [SETTLE_W-1:0] settle_us = 14'd300;
	act_t pending_actions[$];
	int mismatches = 0;
	int sender_idle_pct = 0;
	int stall_pct = 0;
	int holdoff_left = 0;
	int cycle_count = 0;

	always #CLK_HALF clk = ~clk;

	lcd_nibble_write_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	task automatic push_action(input logic [3:0] nib, input logic rs, input logic en,
			input logic [HOLD_W-1:0] hold, input logic fin);
		act_t a;
		a.data_nibble = nib;
		a.reg_select = rs;
		a.enable = en;
		a.hold_us = hold;
		a.last = fin;
		pending_actions.push_back(a);
	endtask

	// seven pin actions per byte; RS flips on the settle action
	task automatic push_byte(input logic rs, input logic [7:0] b, input logic [11:0] extra,
			input logic fin);
		logic [HOLD_W-1:0] s;
		logic [3:0] nib;
		s = HOLD_W'(strobe_us);
		for (int h = 0; h < 2; h++) begin
			nib = (h == 0) ? b[7:4] : b[3:0];
			push_action(nib, rs, 1'b0, s, 1'b0);
			push_action(nib, rs, 1'b1, s, 1'b0);
			push_action(nib, rs, 1'b0, s, 1'b0);
		end
		push_action(b[3:0], ~rs, 1'b0, HOLD_W'(settle_us) + HOLD_W'(extra), fin);
	endtask

	task automatic predict_actions(input req_t r);
		logic [HOLD_W-1:0] s;
		s = HOLD_W'(strobe_us);
		case (r.func)
			FUNC_CMD: push_byte(1'b0, r.value, r.extra_hold_us, 1'b1);
			FUNC_DATA: push_byte(1'b1, r.value, r.extra_hold_us, 1'b1);
			FUNC_INIT: begin
				push_action(4'h0, 1'b0, 1'b0, POWERUP_HOLD, 1'b0);
				push_action(4'h3, 1'b0, 1'b0, s, 1'b0);
				push_action(4'h3, 1'b0, 1'b1, s, 1'b0);
				push_action(4'h3, 1'b0, 1'b0, WAKE_LONG_HOLD + s, 1'b0);
				push_action(4'h3, 1'b0, 1'b1, s, 1'b0);
				push_action(4'h3, 1'b0, 1'b0, WAKE_SHORT_HOLD, 1'b0);
				push_action(4'h3, 1'b0, 1'b1, s, 1'b0);
				push_action(4'h3, 1'b0, 1'b0, WAKE_SHORT_HOLD, 1'b0);
				push_action(4'h2, 1'b0, 1'b0, s, 1'b0);
				push_action(4'h2, 1'b0, 1'b1, s, 1'b0);
				push_action(4'h2, 1'b0, 1'b0, WAKE_4BIT_HOLD, 1'b0);
				for (int i = 0; i < 5; i++)
					push_byte(1'b0, STARTUP_BYTES[i], STARTUP_GAPS[i], i == 4);
			end
			default: ; // unused code: accepted, nothing comes out
		endcase
	endtask

	task automatic send_request(input logic [1:0] func, input logic [7:0] value,
			input logic [11:0] extra);
		req_t r;
		r.func = func;
		r.value = value;
		r.extra_hold_us = extra;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_data = r;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_actions(r);
	endtask

	// drop valid, let every expected action arrive, then keep checking the output for stray actions
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_actions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [13:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		if (idx == CFG_STROBE)
			strobe_us = data[STROBE_W-1:0];
		else
			settle_us = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic check_action(input act_t got);
		act_t want;
		if (pending_actions.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("unexpected action: nib %h rs %b e %b hold %0d last %b",
					got.data_nibble, got.reg_select, got.enable, got.hold_us, got.last);
		end else begin
			want = pending_actions.pop_front();
			if (got.data_nibble !== want.data_nibble || got.reg_select !== want.reg_select ||
					got.enable !== want.enable || got.hold_us !== want.hold_us ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("action mismatch: expected nib %h rs %b e %b hold %0d last %b,",
						want.data_nibble, want.reg_select, want.enable, want.hold_us,
						want.last,
						" got nib %h rs %b e %b hold %0d last %b",
						got.data_nibble, got.reg_select, got.enable, got.hold_us,
						got.last);
			end
		end
	endtask

	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			out_ready = 1'b0;
			holdoff_left--;
		end else begin
			out_ready = ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lcd_nibble_write_sequencer test failed");
			$finish;
		end else if (arst_n && out_valid && out_ready) begin
			check_action(out_data);
		end
	end

	task automatic test_default_timing();
		send_request(FUNC_INIT, 8'h00, 12'h000);
		send_request(FUNC_CMD, 8'h00, 12'h000);
		send_request(FUNC_DATA, 8'hff, 12'hfff);
		send_request(FUNC_CMD, 8'h01, CLEAR_EXTRA);
		send_request(FUNC_CMD, 8'h02, CLEAR_EXTRA);
		send_request(FUNC_NONE, 8'hff, 12'hfff);
		send_request(FUNC_DATA, 8'h5a, 12'h800);
		send_request(FUNC_NONE, 8'h00, 12'h000);
		send_request(FUNC_CMD, 8'ha5, 12'h001);
		send_request(FUNC_INIT, 8'hff, 12'hfff);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_STROBE, 14'd0);
		write_reg(CFG_SETTLE, 14'd0);
		send_request(FUNC_DATA, 8'hff, 12'h000);
		send_request(FUNC_CMD, 8'h00, 12'hfff);
		send_request(FUNC_INIT, 8'h00, 12'h000);
		wait_idle();
		// upper bits of the strobe write fall outside the register
		write_reg(CFG_STROBE, 14'h3fff);
		write_reg(CFG_SETTLE, 14'h3fff);
		send_request(FUNC_INIT, 8'h00, 12'h000);
		send_request(FUNC_DATA, 8'h81, 12'hfff);
		send_request(FUNC_CMD, 8'h7e, 12'h000);
		wait_idle();
		write_reg(CFG_STROBE, 14'd1000);
		write_reg(CFG_SETTLE, 14'd10000);
		send_request(FUNC_CMD, 8'h3c, 12'd4095);
		send_request(FUNC_DATA, 8'hc3, CLEAR_EXTRA);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int rcv_pct, input int count);
		int sent;
		int pick;
		logic [1:0] func;
		logic [11:0] extra;
		sender_idle_pct = idle_pct;
		stall_pct = rcv_pct;
		write_reg(CFG_STROBE, 14'($urandom_range(16383)));
		write_reg(CFG_SETTLE, 14'($urandom_range(16383)));
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 4)
				func = FUNC_INIT;
			else if (pick < 9)
				func = FUNC_NONE;
			else if (pick < 55)
				func = FUNC_CMD;
			else
				func = FUNC_DATA;
			extra = ($urandom_range(9) == 0) ? CLEAR_EXTRA : 12'($urandom_range(4095));
			send_request(func, 8'($urandom_range(255)), extra);
			if (func != FUNC_NONE)
				sent++;
		end
		wait_idle();
	endtask

	// receiver holds off while requests keep coming, so the input backs up
	task automatic test_output_backpressure();
		sender_idle_pct = 0;
		stall_pct = 0;
		write_reg(CFG_STROBE, 14'd25);
		write_reg(CFG_SETTLE, 14'd300);
		@(negedge clk);
		holdoff_left = 400;
		for (int i = 0; i < 8; i++)
			send_request((i % 2 == 0) ? FUNC_CMD : FUNC_DATA, 8'($urandom_range(255)),
				12'($urandom_range(4095)));
		send_request(FUNC_INIT, 8'h00, 12'h000);
		wait_idle();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		test_default_timing();
		test_register_extremes();
		test_random_traffic(0, 0, RANDOM_PER_PHASE);
		test_random_traffic(81, 0, RANDOM_PER_PHASE);
		test_random_traffic(0, 81, RANDOM_PER_PHASE);
		test_random_traffic(12, 12, RANDOM_PER_PHASE);
		test_output_backpressure();
		if (mismatches == 0 && pending_actions.size() == 0)
			$display("lcd_nibble_write_sequencer test passed");
		else
			$display("lcd_nibble_write_sequencer test failed");
		$finish;
	end

endmodule
